[rtl/talk_response_indicator_macros.svh]
// ----------------------------------------------------------------------------
// Talk response indicator assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TALK_RESPONSE_INDICATOR_MACROS_SVH
`define TALK_RESPONSE_INDICATOR_MACROS_SVH

// same-cycle implication
`define TRIND_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("talk_response_indicator assertion failed");

// next-cycle implication
`define TRIND_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("talk_response_indicator assertion failed");

`endif

[rtl/trind_pkg.sv]
// ----------------------------------------------------------------------------
// Talk response indicator package
// Action and response codes, NACK blink timing and the NACK pattern function.
// ----------------------------------------------------------------------------
package trind_pkg;

	typedef enum logic [2:0] {
		ACT_NEW_UTTERANCE = 3'd0,
		ACT_SET_SESSION   = 3'd1,
		ACT_POLL_WAITING  = 3'd2,
		ACT_SET_RESPONSE  = 3'd3,
		ACT_SESSION_ERROR = 3'd4,
		ACT_LED_UPDATE    = 3'd5
	} action_t;

	localparam logic [1:0] RESP_NONE = 2'd0;
	localparam logic [1:0] RESP_ACK  = 2'd1;
	localparam logic [1:0] RESP_NACK = 2'd2;

	localparam logic [0:0] REG_RESPONSE_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_ACK_HOLD         = 1'd1;

	localparam logic [31:0] RESPONSE_TIMEOUT_RESET = 32'd75000;
	localparam logic [15:0] ACK_HOLD_RESET         = 16'd2000;

	// 2400 ms cycle = 75 * 32; the low five bits of time pass straight through
	localparam int unsigned NACK_LOW_BITS  = 5;
	localparam logic [26:0] NACK_CYCLE_UNITS = 27'd75;
	// ceil(2^33 / 75): exact quotient for every 27-bit dividend
	localparam logic [26:0] NACK_RECIP       = 27'd114532462;
	localparam int unsigned NACK_RECIP_SHIFT = 33;

	localparam logic [11:0] NACK_FAST_SPAN_MS = 12'd800;

	// LED level for a phase within the 2400 ms NACK cycle
	function automatic logic nack_led(input logic [11:0] phase);
		logic fast_band;
		logic slow_band;
		fast_band = (phase >= 12'd100) ^ (phase >= 12'd200) ^ (phase >= 12'd300) ^
			(phase >= 12'd400) ^ (phase >= 12'd500) ^ (phase >= 12'd600) ^
			(phase >= 12'd700);
		slow_band = (phase >= 12'd1200) ^ (phase >= 12'd1600) ^ (phase >= 12'd2000);
		if (phase < NACK_FAST_SPAN_MS) begin
			nack_led = ~fast_band;
		end else begin
			nack_led = ~slow_band;
		end
	endfunction

endpackage

[rtl/trind_nack_phase.sv]
// ----------------------------------------------------------------------------
// NACK blink phase
// Two-stage now_ms mod 2400 by reciprocal multiply; yields the NACK LED level.
// ----------------------------------------------------------------------------
module trind_nack_phase (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] now_ms,
	output logic        nack_led
);

	localparam int unsigned XW = 32 - trind_pkg::NACK_LOW_BITS;

	logic [XW-1:0]   x;
	logic [2*XW-1:0] prod;
	logic [20:0]     quot_s2;
	logic [XW-1:0]   x_s2;
	logic [trind_pkg::NACK_LOW_BITS-1:0] low_s2;
	logic [XW-1:0]   rem_full;
	logic [11:0]     phase;
	logic            nack_s3;

	assign x    = now_ms[31:trind_pkg::NACK_LOW_BITS];
	assign prod = (2*XW)'(x) * (2*XW)'(trind_pkg::NACK_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2 <= prod[trind_pkg::NACK_RECIP_SHIFT +: 21];
			x_s2    <= x;
			low_s2  <= now_ms[trind_pkg::NACK_LOW_BITS-1:0];
		end
	end

	// remainder < 75, so seven bits; phase = rem * 32 + low
	assign rem_full = x_s2 - XW'(XW'(quot_s2) * trind_pkg::NACK_CYCLE_UNITS);
	assign phase    = {rem_full[6:0], low_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			nack_s3 <= trind_pkg::nack_led(phase);
		end
	end

	assign nack_led = nack_s3;

endmodule

[rtl/talk_response_indicator.sv]
// ----------------------------------------------------------------------------
// Talk response indicator
// Push-to-talk session tracker with response wait timer and LED driver.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Width  Contents
// s_*      in   104+3  tdata: now_ms, new_session, response_code; tuser: action
// m_*      out  72     tdata: led_on, waiting, current_session
// cfg_*    in   1+32   register index, write data (write enable cfg_we)
//
// One word enters per cycle while s_tready is high; its result word is offered on
// m_* once it has passed the input register, two stages of the now_ms mod 2400
// reciprocal multiply, then the session state update that loads the result register.
// The whole pipeline advances together; s_tready drops only while a result
// sits in the output register with m_tready low.
// arst_n clears the pipeline valids, session state and registers to reset.
//
module talk_response_indicator (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // [31:0] now_ms, [95:32] new_session, [97:96] response_code
	input  logic [2:0]   s_tuser,  // [2:0] action
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // [0] led_on, [1] waiting, [65:2] current_session
);

	// config registers
	logic [31:0] timeout_q;
	logic [15:0] ack_hold_q;

	// pipeline
	logic        adv;
	logic        valid_s1, valid_s2, valid_s3;
	logic [2:0]  act_s1, act_s2, act_s3;
	logic [31:0] now_s1, now_s2, now_s3;
	logic [63:0] sess_in_s1, sess_in_s2, sess_in_s3;
	logic [1:0]  code_s1, code_s2, code_s3;
	logic        nack_led;

	// session state; led/session/waiting also form the result word
	logic [63:0] session_q;
	logic [1:0]  response_q;
	logic [31:0] wait_start_q;
	logic [31:0] deadline_q;
	logic        led_q;
	logic        waiting_q;
	logic        out_valid_q;

	logic [63:0] session_d;
	logic [1:0]  response_d;
	logic [31:0] wait_start_d;
	logic [31:0] deadline_d;
	logic        led_d;
	logic        waiting_d;
	logic [31:0] elapsed;
	logic [31:0] ack_left;

	// everything moves unless a result is stuck at the output
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= trind_pkg::RESPONSE_TIMEOUT_RESET;
			ack_hold_q <= trind_pkg::ACK_HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				trind_pkg::REG_RESPONSE_TIMEOUT: timeout_q  <= cfg_wdata;
				trind_pkg::REG_ACK_HOLD:         ack_hold_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// payload carried alongside the phase pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1     <= s_tuser;
			now_s1     <= s_tdata[31:0];
			sess_in_s1 <= s_tdata[95:32];
			code_s1    <= s_tdata[97:96];
			act_s2     <= act_s1;
			now_s2     <= now_s1;
			sess_in_s2 <= sess_in_s1;
			code_s2    <= code_s1;
			act_s3     <= act_s2;
			now_s3     <= now_s2;
			sess_in_s3 <= sess_in_s2;
			code_s3    <= code_s2;
		end
	end

	// NACK level for now_s1, ready alongside stage 3
	trind_nack_phase u_phase (
		.clk      (clk),
		.en       (adv),
		.now_ms   (now_s1),
		.nack_led (nack_led)
	);

	assign elapsed  = now_s3 - wait_start_q;
	assign ack_left = deadline_q - now_s3;

	always_comb begin
		session_d    = session_q;
		response_d   = response_q;
		wait_start_d = wait_start_q;
		deadline_d   = deadline_q;
		led_d        = led_q;
		waiting_d    = 1'b0;
		case (trind_pkg::action_t'(act_s3))
			trind_pkg::ACT_NEW_UTTERANCE: begin
				session_d    = '0;
				response_d   = trind_pkg::RESP_NONE;
				wait_start_d = '0;
				deadline_d   = '0;
				led_d        = 1'b0;
			end
			trind_pkg::ACT_SET_SESSION: begin
				session_d    = sess_in_s3;
				response_d   = trind_pkg::RESP_NONE;
				wait_start_d = '0;
			end
			trind_pkg::ACT_POLL_WAITING: begin
				if (session_q == '0 || response_q != trind_pkg::RESP_NONE) begin
					waiting_d = 1'b0;
				end else if (wait_start_q == '0) begin
					// zero start means "not started", so time zero starts at one
					wait_start_d = (now_s3 == '0) ? 32'd1 : now_s3;
					waiting_d    = 1'b1;
				end else if (elapsed >= timeout_q) begin
					session_d    = '0;
					response_d   = trind_pkg::RESP_NONE;
					wait_start_d = '0;
					led_d        = 1'b0;
				end else begin
					waiting_d = 1'b1;
				end
			end
			trind_pkg::ACT_SET_RESPONSE: begin
				response_d   = code_s3;
				wait_start_d = '0;
				if (code_s3 == trind_pkg::RESP_ACK) begin
					deadline_d = now_s3 + 32'(ack_hold_q);
					led_d      = 1'b1;
				end else if (code_s3 == trind_pkg::RESP_NACK) begin
					deadline_d = '0;
				end else begin
					deadline_d = '0;
					led_d      = 1'b0;
				end
			end
			trind_pkg::ACT_SESSION_ERROR: begin
				// deadline kept; unreachable once the response is cleared
				session_d    = '0;
				response_d   = trind_pkg::RESP_NONE;
				wait_start_d = '0;
				led_d        = 1'b0;
			end
			trind_pkg::ACT_LED_UPDATE: begin
				if (response_q == trind_pkg::RESP_ACK) begin
					// still lit while the deadline lies strictly ahead
					if (ack_left != '0 && !ack_left[31]) begin
						led_d = 1'b1;
					end else begin
						session_d    = '0;
						response_d   = trind_pkg::RESP_NONE;
						wait_start_d = '0;
						deadline_d   = '0;
						led_d        = 1'b0;
					end
				end else if (response_q == trind_pkg::RESP_NACK) begin
					led_d = nack_led;
				end else begin
					led_d = 1'b0;
				end
			end
			default: ;  // unused actions leave state alone but clear waiting
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q    <= '0;
			response_q   <= trind_pkg::RESP_NONE;
			wait_start_q <= '0;
			deadline_q   <= '0;
			led_q        <= 1'b0;
			waiting_q    <= 1'b0;
		end else if (adv && valid_s3) begin
			session_q    <= session_d;
			response_q   <= response_d;
			wait_start_q <= wait_start_d;
			deadline_q   <= deadline_d;
			led_q        <= led_d;
			waiting_q    <= waiting_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, session_q, waiting_q, led_q};

endmodule

[rtl/trind_checker.sv]
// ----------------------------------------------------------------------------
// Talk response indicator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "talk_response_indicator_macros.svh"

module trind_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// stalled result holds
	`TRIND_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a stuck result blocks the input side
	`TRIND_ASSERT_SAME(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)

	// waiting is only reported with a session held
	`TRIND_ASSERT_SAME(a_wait_has_session, m_tvalid && m_tdata[1], m_tdata[65:2] != '0)

	// pad bits stay zero
	`TRIND_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[71:66] == '0)

endmodule

bind talk_response_indicator trind_checker u_trind_checker (.*);
